FILE: rtl/idw_depth_interpolator_defines.svh
// assertion macros used by idw_back
`ifndef IDW_DEPTH_INTERPOLATOR_DEFINES_SVH
`define IDW_DEPTH_INTERPOLATOR_DEFINES_SVH

// condition must hold at every clock edge outside reset
`define IDW_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define IDW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/idw_pkg.sv
// ----------------------------------------------------------------------------
// idw_pkg
// shared types and constants of the depth interpolator
// ----------------------------------------------------------------------------
package idw_pkg;
	localparam int MAX_POINTS = 1024;
	localparam int ADDR_W = $clog2(MAX_POINTS);
	localparam int CNT_W = 11;
	localparam int MEM_W = 64;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_LOAD,
		CMD_QUERY
	} cmd_kind_t;

	typedef enum logic [2:0] {
		ST_STORED  = 3'd0,
		ST_FULL    = 3'd1,
		ST_INTERP  = 3'd2,
		ST_EXACT   = 3'd3,
		ST_NODATA  = 3'd4,
		ST_CLEARED = 3'd5
	} status_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [15:0] depth;
	} cmd_t;
endpackage

FILE: rtl/idw_ram.sv
// ----------------------------------------------------------------------------
// idw_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module idw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/idw_front.sv
// ----------------------------------------------------------------------------
// idw_front
// accepts input words, decodes the function and queues commands
// ----------------------------------------------------------------------------
module idw_front import idw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [15:0] sample_depth,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);
	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	cmd_t       dec;
	logic       push;
	logic       pop;

	// only bit 1 matters for a query
	always_comb begin
		dec.x = pos_x;
		dec.y = pos_y;
		dec.depth = sample_depth;
		priority if (func[1]) begin
			dec.kind = CMD_QUERY;
		end else if (func[0]) begin
			dec.kind = CMD_LOAD;
		end else begin
			dec.kind = CMD_CLEAR;
		end
	end

	assign in_ready = (fill_q != 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign cmd = entry_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

FILE: rtl/idw_div.sv
// ----------------------------------------------------------------------------
// idw_div
// restoring divider, one quotient bit per cycle, msb-aligned dividend
// ----------------------------------------------------------------------------
module idw_div import idw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [49:0] den,
	input  logic [6:0]  iters,
	output logic        busy,
	output logic        done,
	output logic [63:0] quo
);
	logic [63:0] num_q;
	logic [49:0] den_q;
	logic [49:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [50:0] remx;
	logic [50:0] diff;
	logic        ge;

	assign remx = {rem_q, num_q[63]};
	assign ge = (remx >= {1'b0, den_q});
	assign diff = remx - {1'b0, den_q};
	assign busy = busy_q;
	assign done = done_q;
	assign quo = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[62:0], 1'b0};
			rem_q <= ge ? diff[49:0] : remx[49:0];
			quo_q <= {quo_q[62:0], ge};
		end
	end
endmodule

FILE: rtl/idw_back.sv
// ----------------------------------------------------------------------------
// idw_back
// executes commands: point store, query walk, weighting and final divide
// ----------------------------------------------------------------------------
`include "idw_depth_interpolator_defines.svh"

module idw_back import idw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  cmd_t               cmd,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] result_depth,
	output logic [2:0]         status,
	output logic [CNT_W-1:0]   points_held
);
	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_DIFF, S_SQ, S_SUM, S_WDIV, S_MUL, S_ACC, S_FIN, S_FDIV, S_EMIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic signed [23:0]  qx_q;
	logic signed [23:0]  qy_q;
	logic signed [24:0]  dx_q;
	logic signed [24:0]  dy_q;
	logic [48:0]         dx2_q;
	logic [48:0]         dy2_q;
	logic signed [15:0]  pd_q;
	logic [36:0]         w_q;
	logic signed [53:0]  term_q;
	logic signed [63:0]  acc_q;
	logic [46:0]         wsum_q;
	logic signed [15:0]  res_depth_q;
	status_t             res_status_q;
	logic                out_valid_q;
	logic signed [15:0]  out_depth_q;
	logic [2:0]          out_status_q;
	logic [CNT_W-1:0]    out_held_q;

	logic                we;
	logic [MEM_W-1:0]    rdata;
	logic signed [23:0]  rd_x;
	logic signed [23:0]  rd_y;
	logic signed [15:0]  rd_d;
	logic [49:0]         d2;
	logic signed [49:0]  sqx;
	logic signed [49:0]  sqy;
	logic signed [53:0]  prod;
	logic                div_start;
	logic [63:0]         div_num;
	logic [49:0]         div_den;
	logic [6:0]          div_iters;
	logic                div_busy;
	logic                div_done;
	logic [63:0]         div_quo;
	logic                neg;
	logic [63:0]         mag;
	logic [15:0]         qclamp;
	logic                full;

	assign full = (cnt_q == CNT_W'(MAX_POINTS));
	assign cmd_ready = (state_q == S_IDLE);
	assign we = cmd_ready && cmd_valid && (cmd.kind == CMD_LOAD) && !full;

	idw_ram #(.WIDTH(MEM_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata ({cmd.x, cmd.y, cmd.depth}),
		.raddr (idx_q[ADDR_W-1:0]),
		.rdata (rdata)
	);

	assign rd_x = rdata[63:40];
	assign rd_y = rdata[39:16];
	assign rd_d = rdata[15:0];
	assign sqx = dx_q * dx_q;
	assign sqy = dy_q * dy_q;
	assign d2 = {1'b0, dx2_q} + {1'b0, dy2_q};
	assign prod = $signed({1'b0, w_q}) * pd_q;

	assign neg = acc_q[63];
	assign mag = neg ? 64'(-acc_q) : 64'(acc_q);
	assign qclamp = (div_quo > 64'd32768) ? 16'd32768 : div_quo[15:0];

	// weight walk: numerator 2^36 msb-aligned, 37 quotient bits
	always_comb begin
		div_start = 1'b0;
		div_num = 64'h8000_0000_0000_0000;
		div_den = d2;
		div_iters = 7'd37;
		if (state_q == S_SUM && d2 != 50'd0) begin
			div_start = 1'b1;
		end else if (state_q == S_FIN) begin
			div_start = 1'b1;
			div_num = mag;
			div_den = {3'b0, wsum_q};
			div_iters = 7'd64;
		end
	end

	idw_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (div_den),
		.iters (div_iters),
		.busy  (div_busy),
		.done  (div_done),
		.quo   (div_quo)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				qx_q <= cmd.x;
				qy_q <= cmd.y;
			end
			S_DIFF: begin
				dx_q <= 25'(qx_q) - 25'(rd_x);
				dy_q <= 25'(qy_q) - 25'(rd_y);
				pd_q <= rd_d;
			end
			S_SQ: begin
				dx2_q <= sqx[48:0];
				dy2_q <= sqy[48:0];
			end
			S_WDIV: begin
				w_q <= (div_quo[36:0] == 37'd0) ? 37'd1 : div_quo[36:0];
			end
			S_MUL: begin
				term_q <= prod;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			idx_q <= '0;
			acc_q <= '0;
			wsum_q <= '0;
			res_depth_q <= '0;
			res_status_q <= ST_CLEARED;
			out_valid_q <= 1'b0;
			out_depth_q <= '0;
			out_status_q <= '0;
			out_held_q <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						res_depth_q <= '0;
						state_q <= S_EMIT;
						unique case (cmd.kind)
							CMD_CLEAR: begin
								cnt_q <= '0;
								res_status_q <= ST_CLEARED;
							end
							CMD_LOAD: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else begin
									cnt_q <= cnt_q + CNT_W'(1);
									res_status_q <= ST_STORED;
								end
							end
							CMD_QUERY: begin
								if (cnt_q == '0) begin
									res_status_q <= ST_NODATA;
								end else begin
									idx_q <= '0;
									acc_q <= '0;
									wsum_q <= '0;
									state_q <= S_RD;
								end
							end
							default: begin
								res_status_q <= ST_NODATA;
							end
						endcase
					end
				end
				S_RD: state_q <= S_DIFF;
				S_DIFF: state_q <= S_SQ;
				S_SQ: state_q <= S_SUM;
				S_SUM: begin
					if (d2 == 50'd0) begin
						// first exact hit in load order wins
						res_depth_q <= pd_q;
						res_status_q <= ST_EXACT;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WDIV;
					end
				end
				S_WDIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					wsum_q <= wsum_q + 47'(w_q);
					state_q <= S_ACC;
				end
				S_ACC: begin
					acc_q <= acc_q + 64'(term_q);
					idx_q <= idx_q + CNT_W'(1);
					state_q <= (idx_q + CNT_W'(1) == cnt_q) ? S_FIN : S_RD;
				end
				S_FIN: state_q <= S_FDIV;
				S_FDIV: begin
					if (div_done) begin
						res_status_q <= ST_INTERP;
						if (neg) begin
							res_depth_q <= $signed(16'(-qclamp));
						end else if (qclamp == 16'd32768) begin
							res_depth_q <= 16'sd32767;
						end else begin
							res_depth_q <= $signed(qclamp);
						end
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_depth_q <= res_depth_q;
						out_status_q <= res_status_q;
						out_held_q <= cnt_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign result_depth = out_depth_q;
	assign status = out_status_q;
	assign points_held = out_held_q;

	`IDW_ASSERT_ALWAYS(a_cnt_range, cnt_q <= CNT_W'(MAX_POINTS), "point count above capacity")
	`IDW_ASSERT_ALWAYS(a_div_idle, !(div_start && div_busy), "divider restarted while busy")
	`IDW_ASSERT_NEXT(a_load_count, we, cnt_q == $past(cnt_q) + CNT_W'(1), "load did not bump count")
endmodule

FILE: rtl/idw_depth_interpolator.sv
// ----------------------------------------------------------------------------
// idw_depth_interpolator
// inverse-distance-squared depth interpolation over a store of sample points
// ----------------------------------------------------------------------------
// input channel in_valid/in_ready carries func, pos_x, pos_y, sample_depth;
// output channel out_valid/out_ready returns one word per input word with
// result_depth, status and points_held, in input order.
// a two-entry command queue lets the input side accept words while the
// executor works or while a result waits on a stalled receiver.
// clear and load pass from the queue through S_EMIT to the output register.
// in a query over n points each point costs a
// ram read, a difference, a squaring and a sum stage, a run of the
// shared serial divider for its weight and two accumulate stages; the
// final 64-step divide by the weight sum sets the tail.
// an exact hit ends the walk at the matching point.
// reset empties the point store and queue; ram contents are not cleared.
// when out_ready is low the result holds and the queue fills, then
// in_ready drops.
module idw_depth_interpolator import idw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [15:0] sample_depth,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] result_depth,
	output logic [2:0]         status,
	output logic [10:0]        points_held
);
	logic cmd_valid;
	logic cmd_ready;
	cmd_t cmd;

	idw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.sample_depth (sample_depth),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd)
	);

	idw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_depth (result_depth),
		.status       (status),
		.points_held  (points_held)
	);
endmodule
